// ===== design/opta_pkg.sv =====
package opta_pkg;

    // Tile geometry
    localparam int ROWS  = 16;
    localparam int COLS  = 64;
    localparam int GROUP = 4;

    localparam int DEPTH  = ROWS * COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int AROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int URW    = $clog2(ROWS + 1);
    localparam int UCW    = $clog2(COLS + 1);

    // Item and result fields
    localparam int ACTION_W = 3;
    localparam int ROW_W    = 4;
    localparam int COL_W    = 6;
    localparam int DATA_W   = 8 * GROUP;
    localparam int VALUE_W  = 32;
    localparam int PROD_W   = 16;
    localparam int DOT_W    = PROD_W + 2;

    // Configuration registers
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_ROWS_W = 5;
    localparam int CFG_COLS_W = 7;

    localparam logic [CFG_IDX_W-1:0]  CFG_ROWS_IDX   = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_COLS_IDX   = 1'b1;
    localparam logic [CFG_ROWS_W-1:0] CFG_ROWS_RESET = 5'd16;
    localparam logic [CFG_COLS_W-1:0] CFG_COLS_RESET = 7'd64;

    // Actions
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_LOADA = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ACC   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ  = 3'd4;

    typedef struct packed {
        logic take;        // capture the transferred item, reset the counter
        logic clr_wr;      // write zero at the sweep counter
        logic ld_wr;       // write one accumulator from the item
        logic lda_wr;      // store the item as an A group
        logic acc_issue;   // start one row through the dot pipeline
        logic rd_en;       // read the accumulator addressed by the item
        logic out_load;    // move the read data into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic acc_go;      // column used and at least one row used
        logic row_last;    // counter sits on the last used row
        logic clr_last;    // counter sits on the last tile entry
        logic pipe_busy;   // accumulate writes still pending
        logic out_free;    // output register can take a result
    } t_dp_status;

endpackage

// ===== design/opta_in_if.sv =====
interface opta_in_if;
    logic                            valid;
    logic                            ready;
    logic [opta_pkg::ACTION_W-1:0]   action;
    logic [opta_pkg::ROW_W-1:0]      row;
    logic [opta_pkg::COL_W-1:0]      col;
    logic [opta_pkg::DATA_W-1:0]     data;

    modport source (output valid, action, row, col, data, input ready);
    modport sink   (input valid, action, row, col, data, output ready);
endinterface

// ===== design/opta_out_if.sv =====
interface opta_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [opta_pkg::VALUE_W-1:0] value;
    logic                                in_range;

    modport source (output valid, value, in_range, input ready);
    modport sink   (input valid, value, in_range, output ready);
endinterface

// ===== design/opta_ctrl.sv =====
module opta_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [opta_pkg::ACTION_W-1:0] i_action,
    input  opta_pkg::t_dp_status          i_status,
    output logic                          o_in_ready,
    output opta_pkg::t_dp_cmd             o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_LOADA = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_READ  = 3'd6;
    localparam logic [2:0] S_RESP  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    unique case (i_action)
                        opta_pkg::ACT_CLEAR: n_state = S_CLEAR;
                        opta_pkg::ACT_LOAD:  n_state = S_LOAD;
                        opta_pkg::ACT_LOADA: n_state = S_LOADA;
                        opta_pkg::ACT_ACC:   n_state = S_ACC;
                        opta_pkg::ACT_READ:  n_state = S_READ;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_LOAD: begin
                o_cmd.ld_wr = 1'b1;
                n_state     = S_IDLE;
            end
            S_LOADA: begin
                o_cmd.lda_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_ACC: begin
                // drop the item when its column or every row is masked
                if (!i_status.acc_go) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.acc_issue = 1'b1;
                    if (i_status.row_last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_RESP;
            end
            S_RESP: begin
                // hold the read data until the output register frees up
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_idle_no_pending_writes: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_status.pipe_busy
    ) else $error("accumulate writes pending while idle");

    a_one_memory_op: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.clr_wr, o_cmd.ld_wr, o_cmd.lda_wr, o_cmd.acc_issue, o_cmd.rd_en})
    ) else $error("more than one memory operation commanded");
`endif

endmodule

// ===== design/opta_datapath.sv =====
module opta_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  opta_pkg::t_dp_cmd                    i_cmd,
    input  logic [opta_pkg::ROW_W-1:0]           i_row,
    input  logic [opta_pkg::COL_W-1:0]           i_col,
    input  logic [opta_pkg::DATA_W-1:0]          i_data,
    input  logic                                 i_cfg_we,
    input  logic [opta_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [opta_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [opta_pkg::VALUE_W-1:0]  o_out_value,
    output logic                                 o_out_in_range,
    output opta_pkg::t_dp_status                 o_status
);

    localparam int ADDR_W = opta_pkg::ADDR_W;
    localparam int DOT_W  = opta_pkg::DOT_W;
    localparam int PROD_W = opta_pkg::PROD_W;

    function automatic logic [ADDR_W-1:0] acc_addr(
        input logic [ADDR_W-1:0]             r,
        input logic [opta_pkg::COL_W-1:0]    c
    );
        return ADDR_W'(r * ADDR_W'(opta_pkg::COLS)) + ADDR_W'(c);
    endfunction

    // Configuration
    logic [opta_pkg::CFG_ROWS_W-1:0] r_rows_in_use;
    logic [opta_pkg::CFG_COLS_W-1:0] r_cols_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= opta_pkg::CFG_ROWS_RESET;
            r_cols_in_use <= opta_pkg::CFG_COLS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                opta_pkg::CFG_ROWS_IDX:
                    r_rows_in_use <= i_cfg_data[opta_pkg::CFG_ROWS_W-1:0];
                opta_pkg::CFG_COLS_IDX:
                    r_cols_in_use <= i_cfg_data[opta_pkg::CFG_COLS_W-1:0];
                default: ;
            endcase
        end
    end

    logic [opta_pkg::URW-1:0] used_rows;
    logic [opta_pkg::UCW-1:0] used_cols;

    assign used_rows = (int'(r_rows_in_use) < opta_pkg::ROWS)
                     ? opta_pkg::URW'(r_rows_in_use) : opta_pkg::URW'(opta_pkg::ROWS);
    assign used_cols = (int'(r_cols_in_use) < opta_pkg::COLS)
                     ? opta_pkg::UCW'(r_cols_in_use) : opta_pkg::UCW'(opta_pkg::COLS);

    // Captured item
    logic [opta_pkg::ROW_W-1:0]  r_row;
    logic [opta_pkg::COL_W-1:0]  r_col;
    logic [opta_pkg::DATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_row  <= i_row;
            r_col  <= i_col;
            r_data <= i_data;
        end
    end

    logic              col_ok;
    logic              in_extent;
    logic [ADDR_W-1:0] item_addr;

    assign col_ok    = int'(r_col) < int'(used_cols);
    assign in_extent = col_ok && (int'(r_row) < int'(used_rows));
    assign item_addr = acc_addr(ADDR_W'(r_row), r_col);

    // Sweep and row counter
    logic [ADDR_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.take) begin
            r_cnt <= '0;
        end else if (i_cmd.clr_wr || i_cmd.acc_issue) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // A groups, one per row
    logic [opta_pkg::DATA_W-1:0] r_agrp [opta_pkg::ROWS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.lda_wr && (int'(r_row) < opta_pkg::ROWS)) begin
            r_agrp[r_row[opta_pkg::AROW_W-1:0]] <= r_data;
        end
    end

    // Dot pipeline: products, then the lane sum, then the write-back add
    logic [opta_pkg::DATA_W-1:0] a_sel;
    logic [ADDR_W-1:0]           acc_rd_addr;
    logic [ADDR_W-1:0]           rd_addr;

    assign a_sel       = r_agrp[r_cnt[opta_pkg::AROW_W-1:0]];
    assign acc_rd_addr = acc_addr(r_cnt, r_col);
    assign rd_addr     = i_cmd.rd_en ? item_addr : acc_rd_addr;

    logic signed [PROD_W-1:0] r_prod [opta_pkg::GROUP];
    logic                     r_p1_valid;
    logic [ADDR_W-1:0]        r_p1_addr;
    logic signed [DOT_W-1:0]  r_dot;
    logic signed [DOT_W-1:0]  dot_sum;
    logic                     r_p2_valid;
    logic [ADDR_W-1:0]        r_p2_addr;
    logic [opta_pkg::VALUE_W-1:0] r_acc_old;

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_issue) begin
            for (int k = 0; k < opta_pkg::GROUP; k++) begin
                r_prod[k] <= $signed(a_sel[8*k +: 8]) * $signed(r_data[8*k +: 8]);
            end
        end
    end

    always_comb begin
        dot_sum = '0;
        for (int k = 0; k < opta_pkg::GROUP; k++) begin
            dot_sum = dot_sum + DOT_W'(r_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_p1_valid <= i_cmd.acc_issue;
            r_p2_valid <= r_p1_valid;
        end
    end

    // Accumulator memory: one read port, one write port
    logic [opta_pkg::VALUE_W-1:0] mem [opta_pkg::DEPTH];
    logic [opta_pkg::VALUE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        r_p1_addr <= acc_rd_addr;
        r_p2_addr <= r_p1_addr;
        r_dot     <= dot_sum;
        r_acc_old <= r_rd_data;
        if (i_cmd.rd_en || i_cmd.acc_issue) begin
            r_rd_data <= mem[rd_addr];
        end
        if (i_cmd.clr_wr) begin
            mem[r_cnt] <= '0;
        end else if (i_cmd.ld_wr && in_extent) begin
            mem[item_addr] <= r_data;
        end else if (r_p2_valid) begin
            mem[r_p2_addr] <= r_acc_old + opta_pkg::VALUE_W'(r_dot);
        end
    end

    // Output register
    logic                                r_out_valid;
    logic signed [opta_pkg::VALUE_W-1:0] r_out_value;
    logic                                r_out_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value    <= in_extent ? $signed(r_rd_data) : '0;
            r_out_in_range <= in_extent;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_value    = r_out_value;
    assign o_out_in_range = r_out_in_range;

    assign o_status.acc_go    = col_ok && (used_rows != '0);
    assign o_status.row_last  = int'(r_cnt) == int'(used_rows) - 1;
    assign o_status.clr_last  = int'(r_cnt) == opta_pkg::DEPTH - 1;
    assign o_status.pipe_busy = r_p1_valid || r_p2_valid;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

`ifndef SYNTHESIS
    a_write_port_single: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clr_wr, i_cmd.ld_wr, r_p2_valid})
    ) else $error("write port claimed twice");

    a_pipe_advance: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_p1_valid |=> r_p2_valid
    ) else $error("dot pipeline lost a row");

    a_out_loaded: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid
    ) else $error("read result not presented");
`endif

endmodule

// ===== design/outer_product_tile_accumulator_unit.sv =====
// Int8 outer-product tile accumulator: a ROWS x COLS tile of 32-bit accumulators.
// Items arrive on i_in (valid/ready); each clears the tile, loads one accumulator,
// stores a packed A group for a row, accumulates a packed B group into a column,
// or reads one accumulator. Only a read produces a result, on o_out (valid/ready).
// An item is taken only while the controller is idle. Per item:
//   clear       writes every tile entry, one memory entry per cycle
//   load, A     writes one accumulator (in range only) or one A group
//   accumulate  one row per cycle via the shared four-lane dot unit and memory,
//               then drains; drops an item whose column or all rows are masked
//   read        reads, then loads the output register once it is free
//   other codes ignored
// Configuration writes on i_cfg_* take effect at once and must be made while
// idle; the block itself does not enforce this.
// Reset sets rows_in_use to 16 and cols_in_use to 64 and empties the output;
// the accumulators and A groups hold no defined value until cleared or written.
// When o_out stalls, the result stays in the output register and other items
// keep flowing; a further read waits until that register is free.
module outer_product_tile_accumulator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    opta_in_if.sink                           i_in,
    opta_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [opta_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [opta_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    opta_pkg::t_dp_cmd    cmd;
    opta_pkg::t_dp_status status;
    logic                 in_ready;

    opta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_action   (i_in.action),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    opta_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_row          (i_in.row),
        .i_col          (i_in.col),
        .i_data         (i_in.data),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_out_value    (o_out.value),
        .o_out_in_range (o_out.in_range),
        .o_status       (status)
    );

    assign i_in.ready = in_ready;

endmodule
